// ----- rtl/tss_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and defaults for the two-stack shared memory
// no dependencies

package tss_pkg;

    // default sizes, handed down from the top level
    localparam int DEPTH_DEF      = 128;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the item ports
    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOP_W    = 7;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_EMPTY = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_TOP   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // stack select values
    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                stack_sel;
        logic [WORD_W-1:0]   push_value;
    } tss_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic [TOP_W-1:0]    top_index;
    } tss_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;    // latch the accepted request
        logic exec;        // evaluate request, update pointers, touch memory
        logic capture_rd;  // take the registered memory word into the result
    } tss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;  // current request reads a stored word
    } tss_stat_t;

endpackage

// ----- rtl/tss_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/tss_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences one request at a time through execute, an optional read and respond
// depends on tss_pkg

module tss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tss_pkg::tss_cmd_t cmd,
    input  tss_pkg::tss_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   req_ready_reg;
    logic   rsp_valid_reg;
    logic   accept;

    assign accept    = req_valid && req_ready_reg;
    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.load_req   = accept;
        cmd.exec       = (state_reg == S_EXEC);
        cmd.capture_rd = (state_reg == S_READ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg     <= S_EXEC;
                        req_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (stat.needs_read)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg     <= S_RESP;
                        rsp_valid_reg <= 1'b1;
                    end
                end
                S_READ:
                begin
                    state_reg     <= S_RESP;
                    rsp_valid_reg <= 1'b1;
                end
                S_RESP:
                begin
                    if (rsp_ready)
                    begin
                        state_reg     <= S_IDLE;
                        rsp_valid_reg <= 1'b0;
                        req_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    rsp_valid_reg <= 1'b0;
                    req_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- rtl/tss_dp.sv -----
`timescale 1ns / 1ps
// datapath: request register, stack pointers, shared ram and result register
// depends on tss_pkg and tss_ram

module tss_dp #(
    parameter int DEPTH      = tss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tss_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tss_pkg::tss_req_t  req,
    output tss_pkg::tss_rsp_t  rsp,
    input  tss_pkg::tss_cmd_t  cmd,
    output tss_pkg::tss_stat_t stat
);

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);

    tss_pkg::tss_req_t req_reg;
    tss_pkg::tss_rsp_t rsp_reg;

    logic [PTR_W-1:0] lower_count_reg, lower_count_next;
    logic [PTR_W-1:0] upper_base_reg, upper_base_next;
    logic [PTR_W-1:0] lower_dec, upper_dec, top_ptr;

    logic                         full, empty_sel, empty_after;
    logic [tss_pkg::STATUS_W-1:0] status_c;
    logic [PTR_W-1:0]             top_c;
    logic                         rd_req, wr_req;
    logic [ADDR_W-1:0]            wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0]        wr_data, rd_data;

    assign lower_dec = lower_count_reg - 1'b1;
    assign upper_dec = upper_base_reg - 1'b1;
    assign full      = (lower_count_reg >= upper_base_reg);
    assign empty_sel = (req_reg.stack_sel == tss_pkg::SEL_UPPER) ?
                       (upper_base_reg >= DEPTH_PTR) : (lower_count_reg == '0);
    assign top_ptr   = (req_reg.stack_sel == tss_pkg::SEL_UPPER) ? upper_base_reg : lower_dec;
    assign rd_addr   = ADDR_W'(top_ptr);
    assign wr_data   = DATA_WIDTH'(req_reg.push_value);

    always_comb
    begin
        lower_count_next = lower_count_reg;
        upper_base_next  = upper_base_reg;
        status_c         = tss_pkg::ST_OK;
        top_c            = '0;
        rd_req           = 1'b0;
        wr_req           = 1'b0;
        wr_addr          = ADDR_W'(lower_count_reg);
        case (req_reg.opcode)
            tss_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_c = tss_pkg::ST_OVERFLOW;
                end
                else if (req_reg.stack_sel == tss_pkg::SEL_UPPER)
                begin
                    wr_req          = 1'b1;
                    wr_addr         = ADDR_W'(upper_dec);
                    upper_base_next = upper_dec;
                end
                else
                begin
                    wr_req           = 1'b1;
                    lower_count_next = lower_count_reg + 1'b1;
                end
            end
            tss_pkg::OP_POP, tss_pkg::OP_PEEK, tss_pkg::OP_TOP:
            begin
                if (empty_sel)
                begin
                    status_c = tss_pkg::ST_UNDERFLOW;
                end
                else if (req_reg.opcode == tss_pkg::OP_TOP)
                begin
                    top_c = top_ptr;
                end
                else
                begin
                    rd_req = 1'b1;
                    if (req_reg.opcode == tss_pkg::OP_POP)
                    begin
                        if (req_reg.stack_sel == tss_pkg::SEL_UPPER)
                        begin
                            upper_base_next = upper_base_reg + 1'b1;
                        end
                        else
                        begin
                            lower_count_next = lower_dec;
                        end
                    end
                end
            end
            tss_pkg::OP_CLEAR:
            begin
                if (req_reg.stack_sel == tss_pkg::SEL_UPPER)
                begin
                    upper_base_next = DEPTH_PTR;
                end
                else
                begin
                    lower_count_next = '0;
                end
            end
            default:
            begin
                // empty query and unused codes change nothing
                status_c = tss_pkg::ST_OK;
            end
        endcase
    end

    assign empty_after = (req_reg.stack_sel == tss_pkg::SEL_UPPER) ?
                         (upper_base_next >= DEPTH_PTR) : (lower_count_next == '0);

    assign stat.needs_read = rd_req;

    tss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && wr_req),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.exec && rd_req),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_base_reg  <= DEPTH_PTR;
        end
        else if (cmd.exec)
        begin
            lower_count_reg <= lower_count_next;
            upper_base_reg  <= upper_base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg.read_value <= '0;
            rsp_reg.status     <= status_c;
            rsp_reg.is_empty   <= empty_after;
            rsp_reg.top_index  <= tss_pkg::TOP_W'(top_c);
        end
        else if (cmd.capture_rd)
        begin
            rsp_reg.read_value <= tss_pkg::WORD_W'(rd_data);
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/two_stacks_shared_memory.sv -----
`timescale 1ns / 1ps
// top level: two lifo stacks growing towards each other in one shared ram
// depends on tss_pkg, tss_ctrl, tss_dp (and tss_ram below it)
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  request  | req_valid / req_ready  | req : opcode, stack_sel, push_value
//  response | rsp_valid / rsp_ready  | rsp : read_value, status, is_empty, top_index
//
// one item in flight at a time: accept, execute, then the result is offered;
// a pop or peek that reads a word passes through an extra read state for the registered
// ram read, while every other item goes straight from execute to offering the result
// a stalled response holds the block; req_ready returns the cycle after the result is taken
// reset (rst_n low, asynchronous) empties both stacks; the ram itself is not cleared,
// as no word is ever read before it has been pushed

module two_stacks_shared_memory #(
    parameter int DEPTH      = tss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tss_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request items
    input  logic              req_valid,
    output logic              req_ready,
    input  tss_pkg::tss_req_t req,
    // response items
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tss_pkg::tss_rsp_t rsp
);

    // command and status between the sequencer and the datapath
    tss_pkg::tss_cmd_t  cmd;
    tss_pkg::tss_stat_t stat;

    // sequencer: idle, execute, optional ram read, respond
    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: lower stack counts up from index 0, upper stack down from the top;
    // the memory is full when the two pointers meet
    tss_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- tb/tb_two_stacks_shared_memory.sv -----
`timescale 1ns / 1ps
// testbench for two_stacks_shared_memory: directed and random stack requests,
// each result checked against a predictor kept in a small scoreboard class
// depends on tss_pkg and the rtl of two_stacks_shared_memory

module tb_two_stacks_shared_memory;

    localparam int STORE_DEPTH    = tss_pkg::DEPTH_DEF;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 1125;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // opcodes the block leaves alone
    localparam logic [tss_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [tss_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    // shape of a run of random items
    typedef enum int {BURST_GROW, BURST_SHRINK, BURST_NOISE} burst_kind_t;

    // predictor of both stacks plus the queue of results still owed
    class stack_scoreboard;
        logic [tss_pkg::WORD_W-1:0] store [STORE_DEPTH];
        int unsigned                lower_count;
        int unsigned                upper_base;
        tss_pkg::tss_rsp_t          expected_q[$];
        int                         errors;
        int                         checked;

        function new();
            lower_count = 0;
            upper_base  = STORE_DEPTH;
            errors      = 0;
            checked     = 0;
        endfunction

        function bit stack_empty(logic sel);
            return sel ? (upper_base >= STORE_DEPTH) : (lower_count == 0);
        endfunction

        // work out the result of an accepted request and move the state on
        function void note_request(tss_pkg::tss_req_t r);
            tss_pkg::tss_rsp_t want;
            bit                full;
            bit                empty;
            int unsigned       top_at;
            want   = '0;
            full   = lower_count >= upper_base;
            empty  = stack_empty(r.stack_sel);
            top_at = r.stack_sel ? upper_base : lower_count - 1;
            case (r.opcode)
                tss_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        want.status = tss_pkg::ST_OVERFLOW;
                    end
                    else if (r.stack_sel == tss_pkg::SEL_UPPER)
                    begin
                        upper_base--;
                        store[upper_base] = r.push_value;
                    end
                    else
                    begin
                        store[lower_count] = r.push_value;
                        lower_count++;
                    end
                end
                tss_pkg::OP_POP, tss_pkg::OP_PEEK, tss_pkg::OP_TOP:
                begin
                    if (empty)
                    begin
                        want.status = tss_pkg::ST_UNDERFLOW;
                    end
                    else if (r.opcode == tss_pkg::OP_TOP)
                    begin
                        want.top_index = top_at[tss_pkg::TOP_W-1:0];
                    end
                    else
                    begin
                        want.read_value = store[top_at];
                        if (r.opcode == tss_pkg::OP_POP)
                        begin
                            if (r.stack_sel == tss_pkg::SEL_UPPER)
                                upper_base++;
                            else
                                lower_count--;
                        end
                    end
                end
                tss_pkg::OP_CLEAR:
                begin
                    if (r.stack_sel == tss_pkg::SEL_UPPER)
                        upper_base = STORE_DEPTH;
                    else
                        lower_count = 0;
                end
                default: ;
            endcase
            want.is_empty = stack_empty(r.stack_sel);
            expected_q.push_back(want);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task compare_field(string name, logic [tss_pkg::WORD_W-1:0] got,
                           logic [tss_pkg::WORD_W-1:0] want);
            if (got !== want)
                report($sformatf("%s of result %0d: got %h, expected %h",
                                 name, checked, got, want));
        endtask

        task check_response(tss_pkg::tss_rsp_t got);
            tss_pkg::tss_rsp_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("read_value", got.read_value, want.read_value);
            compare_field("status", tss_pkg::WORD_W'(got.status),
                          tss_pkg::WORD_W'(want.status));
            compare_field("is_empty", tss_pkg::WORD_W'(got.is_empty),
                          tss_pkg::WORD_W'(want.is_empty));
            compare_field("top_index", tss_pkg::WORD_W'(got.top_index),
                          tss_pkg::WORD_W'(want.top_index));
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    tss_pkg::tss_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    tss_pkg::tss_rsp_t rsp;

    stack_scoreboard book;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    two_stacks_shared_memory u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 8 ns clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // receiver: ready is redrawn at every falling edge, stalling at the set rate
    always @(negedge clk)
    begin
        rsp_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // results are taken at the rising edge and checked at once
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            book.check_response(rsp);
    end

    // watchdog: any handshake resets the count of quiet cycles
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic tss_pkg::tss_req_t make_req(logic [tss_pkg::OPCODE_W-1:0] op,
                                                   logic sel,
                                                   logic [tss_pkg::WORD_W-1:0] value);
        tss_pkg::tss_req_t r;
        r.opcode     = op;
        r.stack_sel  = sel;
        r.push_value = value;
        return r;
    endfunction

    // one item on the request side; gaps are drawn cycle by cycle, and the
    // payload only ever changes at a falling edge
    task automatic send_req(tss_pkg::tss_req_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = item;
        do
            @(posedge clk);
        while (!req_ready);
        book.note_request(item);
    endtask

    // drop valid and hold off until every owed result has come back
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (book.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // random request in the spirit of the current burst
    function automatic tss_pkg::tss_req_t pick_request(burst_kind_t kind, logic favoured);
        tss_pkg::tss_req_t r;
        int                roll;
        r.push_value = $urandom;
        r.stack_sel  = ($urandom_range(99) < 75) ? favoured : ~favoured;
        roll         = $urandom_range(99);
        case (kind)
            BURST_GROW:
                r.opcode = (roll < 85) ? tss_pkg::OP_PUSH :
                           (roll < 90) ? tss_pkg::OP_TOP  :
                           (roll < 95) ? tss_pkg::OP_PEEK : tss_pkg::OP_EMPTY;
            BURST_SHRINK:
                r.opcode = (roll < 60) ? tss_pkg::OP_POP   :
                           (roll < 75) ? tss_pkg::OP_PEEK  :
                           (roll < 85) ? tss_pkg::OP_TOP   :
                           (roll < 90) ? tss_pkg::OP_PUSH  :
                           (roll < 95) ? tss_pkg::OP_EMPTY : tss_pkg::OP_CLEAR;
            default:
                r.opcode = tss_pkg::OPCODE_W'($urandom_range(7));
        endcase
        return r;
    endfunction

    // bursts that fill towards overflow, drain towards underflow, or mix
    // everything; ignored opcodes do not count towards the target
    task automatic run_phase(int target);
        int                done;
        int                len;
        int                k;
        int                roll;
        burst_kind_t       kind;
        logic              favoured;
        tss_pkg::tss_req_t r;
        done = 0;
        while (done < target)
        begin
            roll     = $urandom_range(99);
            favoured = 1'($urandom_range(1));
            if (roll < 40)
            begin
                kind = BURST_GROW;
                len  = $urandom_range(160, 30);
            end
            else if (roll < 75)
            begin
                kind = BURST_SHRINK;
                len  = $urandom_range(120, 20);
            end
            else
            begin
                kind = BURST_NOISE;
                len  = $urandom_range(30, 5);
            end
            for (k = 0; k < len && done < target; k++)
            begin
                r = pick_request(kind, favoured);
                send_req(r);
                if (r.opcode <= tss_pkg::OP_TOP)
                    done++;
            end
        end
    endtask

    initial
    begin
        book = new();

        // reset held at the start, then released away from the rising edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed items: empty stacks, word extremes, both tops, spare opcodes
        send_req(make_req(tss_pkg::OP_POP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_PEEK,  tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_TOP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_TOP,   tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_EMPTY, tss_pkg::SEL_LOWER, 32'hFFFF_FFFF));
        send_req(make_req(tss_pkg::OP_EMPTY, tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_PUSH,  tss_pkg::SEL_LOWER, 32'h0000_0000));
        send_req(make_req(tss_pkg::OP_PUSH,  tss_pkg::SEL_LOWER, 32'hFFFF_FFFF));
        send_req(make_req(tss_pkg::OP_PUSH,  tss_pkg::SEL_UPPER, 32'hA5A5_A5A5));
        send_req(make_req(tss_pkg::OP_PUSH,  tss_pkg::SEL_UPPER, 32'h5A5A_5A5A));
        send_req(make_req(tss_pkg::OP_TOP,   tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_POP,   tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_TOP,   tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_TOP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_PEEK,  tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_POP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_POP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_POP,   tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_CLEAR, tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(tss_pkg::OP_EMPTY, tss_pkg::SEL_UPPER, 32'h0));
        send_req(make_req(OP_SPARE_6,        tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(OP_SPARE_7,        tss_pkg::SEL_UPPER, 32'hFFFF_FFFF));
        send_req(make_req(tss_pkg::OP_PUSH,  tss_pkg::SEL_LOWER, 32'h1234_5678));
        send_req(make_req(tss_pkg::OP_CLEAR, tss_pkg::SEL_LOWER, 32'h0));
        send_req(make_req(tss_pkg::OP_PEEK,  tss_pkg::SEL_LOWER, 32'h0));
        hold_until_drained();

        // sender idles lightly while the receiver stalls heavily
        send_idle_pct  = 20;
        recv_stall_pct = 73;
        run_phase(RANDOM_ITEMS / 3);
        hold_until_drained();

        // the other way round
        send_idle_pct  = 73;
        recv_stall_pct = 20;
        run_phase(RANDOM_ITEMS / 3);
        hold_until_drained();

        // full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        hold_until_drained();

        // let any stray result show itself before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.expected_q.size() != 0)
            book.report($sformatf("%0d results never arrived", book.expected_q.size()));

        if (book.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
